### src/ead_pkg.sv
`timescale 1ns / 1ps
// Package for the exponential atmosphere density pipeline: band tables,
// fixed-point widths, 2^x lookup tables and the stage payload structs.
// No dependencies.
package ead_pkg;

    localparam int BAND_COUNT    = 23;
    localparam int TABLE_BANDS   = 23;
    localparam int BAND_LIMIT    = (BAND_COUNT < TABLE_BANDS) ? BAND_COUNT : TABLE_BANDS;
    localparam int MANTISSA_BITS = 16;
    localparam int MANT_SHIFT    = 30 - MANTISSA_BITS;
    localparam int ROUND_HALF    = (MANT_SHIFT > 0) ? (1 << (MANT_SHIFT - 1)) : 0;

    localparam int ALT_W   = 23;
    localparam int BAND_W  = 5;
    localparam int DIFF_W  = 24;
    localparam int SLOPE_W = 29;
    localparam int PROD_W  = 54;
    localparam int V_W     = 56;
    localparam int E_W     = 16;
    localparam int J_W     = 6;
    localparam int R_W     = 34;
    localparam int R_HALF  = 17;
    localparam int PP_W    = 42;
    localparam int SUM_W   = 60;
    localparam int BASE_W  = 31;
    localparam int DELTA_W = 25;
    localparam int EXP_W   = 8;
    localparam int LATENCY = 8;

    localparam logic [63:0] LOG2E_Q40 = 64'd1586259972792;
    localparam logic [63:0] Q30_ONE   = 64'd1073741824;

    localparam int BAND_BASE_M [TABLE_BANDS] = '{
        0, 25000, 30000, 40000, 50000, 60000, 70000, 80000, 90000, 100000,
        150000, 200000, 250000, 300000, 350000, 400000, 450000, 500000,
        600000, 700000, 800000, 900000, 1000000
    };

    localparam logic [SLOPE_W-1:0] BAND_SLOPE [TABLE_BANDS] = '{
        SLOPE_W'(LOG2E_Q40 / 7249),   SLOPE_W'(LOG2E_Q40 / 6349),
        SLOPE_W'(LOG2E_Q40 / 6682),   SLOPE_W'(LOG2E_Q40 / 7554),
        SLOPE_W'(LOG2E_Q40 / 8382),   SLOPE_W'(LOG2E_Q40 / 7714),
        SLOPE_W'(LOG2E_Q40 / 6549),   SLOPE_W'(LOG2E_Q40 / 5799),
        SLOPE_W'(LOG2E_Q40 / 5382),   SLOPE_W'(LOG2E_Q40 / 5877),
        SLOPE_W'(LOG2E_Q40 / 22523),  SLOPE_W'(LOG2E_Q40 / 37105),
        SLOPE_W'(LOG2E_Q40 / 45546),  SLOPE_W'(LOG2E_Q40 / 53628),
        SLOPE_W'(LOG2E_Q40 / 53298),  SLOPE_W'(LOG2E_Q40 / 58515),
        SLOPE_W'(LOG2E_Q40 / 60828),  SLOPE_W'(LOG2E_Q40 / 63822),
        SLOPE_W'(LOG2E_Q40 / 71835),  SLOPE_W'(LOG2E_Q40 / 88667),
        SLOPE_W'(LOG2E_Q40 / 124640), SLOPE_W'(LOG2E_Q40 / 181050),
        SLOPE_W'(LOG2E_Q40 / 268000)
    };

    localparam int BAND_LOG2_Q24 [TABLE_BANDS] = '{
        4912063, -78529988, -97590553, -133813710, -165856351, -194732105,
        -226107608, -263064222, -304803966, -349776787, -483984465,
        -532501002, -565117471, -591688700, -614255463, -636962050,
        -657644290, -677539944, -715465013, -749159684, -776457690,
        -795877214, -809246508
    };

    localparam logic [63:0] POW2_STEP [6] = '{
        64'd1518500250, 64'd1276901417, 64'd1170923762,
        64'd1121280436, 64'd1097253708, 64'd1085434106
    };

    typedef logic [(1 << J_W)-1:0][BASE_W-1:0]  pow_base_t;
    typedef logic [(1 << J_W)-1:0][DELTA_W-1:0] pow_delta_t;

    function automatic logic [63:0] mul_q30(logic [63:0] a, logic [63:0] b);
        return (a * b + 64'(1 << 29)) >> 30;
    endfunction

    function automatic logic [63:0] seg_base(int j);
        logic [63:0] b;
        b = Q30_ONE;
        for (int k = 0; k < J_W; k++) begin
            if (((j >> (J_W - 1 - k)) & 1) != 0)
                b = mul_q30(b, POW2_STEP[k]);
        end
        return b;
    endfunction

    function automatic pow_base_t build_pow_base();
        pow_base_t t;
        for (int j = 0; j < (1 << J_W); j++)
            t[j] = BASE_W'(seg_base(j));
        return t;
    endfunction

    function automatic pow_delta_t build_pow_delta();
        pow_delta_t t;
        logic [63:0] b;
        logic [63:0] n;
        for (int j = 0; j < (1 << J_W); j++) begin
            b = seg_base(j);
            n = mul_q30(b, POW2_STEP[J_W-1]);
            if (n < b)
                n = b;
            t[j] = DELTA_W'(n - b);
        end
        return t;
    endfunction

    localparam pow_base_t  POW_BASE  = build_pow_base();
    localparam pow_delta_t POW_DELTA = build_pow_delta();

    typedef struct packed {
        logic [BAND_W-1:0]        band;
        logic signed [DIFF_W-1:0] diff;
        logic [SLOPE_W-1:0]       slope;
        logic signed [31:0]       log2_base;
    } band_out_t;

    typedef struct packed {
        logic [BAND_W-1:0]     band;
        logic signed [E_W-1:0] expo;
        logic [J_W-1:0]        seg;
        logic [R_W-1:0]        rem;
    } log2_out_t;

    typedef struct packed {
        logic [BAND_W-1:0]     band;
        logic signed [E_W-1:0] expo;
        logic [BASE_W-1:0]     mant_q30;
    } exp2_out_t;

endpackage

### src/ead_band.sv
`timescale 1ns / 1ps
// Band search and band table fetch, two register stages.
// Depends on ead_pkg.
module ead_band
    import ead_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic signed [ALT_W-1:0] altitude,
    output logic                    out_valid,
    output band_out_t               out_data
);

    logic                    s1_valid_reg;
    logic [BAND_W-1:0]       s1_band_reg;
    logic [BAND_W-1:0]       s1_band_next;
    logic signed [ALT_W-1:0] s1_alt_reg;
    logic                    s2_valid_reg;
    band_out_t               s2_data_reg;
    band_out_t               s2_data_next;
    logic signed [DIFF_W-1:0] alt_ext;

    // Pick the highest band whose base lies at or below the altitude, band 0 if none does.
    always_comb
    begin
        s1_band_next = '0;
        for (int i = 1; i < BAND_LIMIT; i++) begin
            if (32'(altitude) >= BAND_BASE_M[i])
                s1_band_next = BAND_W'(i);
        end
    end

    assign alt_ext = DIFF_W'(s1_alt_reg);

    always_comb
    begin
        s2_data_next.band      = s1_band_reg;
        s2_data_next.diff      = alt_ext - DIFF_W'(BAND_BASE_M[s1_band_reg]);
        s2_data_next.slope     = BAND_SLOPE[s1_band_reg];
        s2_data_next.log2_base = 32'(BAND_LOG2_Q24[s1_band_reg]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_band_reg <= s1_band_next;
        s1_alt_reg  <= altitude;
        s2_data_reg <= s2_data_next;
    end

    assign out_valid = s2_valid_reg;
    assign out_data  = s2_data_reg;

endmodule

### src/ead_log2.sv
`timescale 1ns / 1ps
// Log2 density: slope multiply, then offset subtract and split into
// exponent and fraction, two register stages. Depends on ead_pkg.
module ead_log2
    import ead_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  band_out_t in_data,
    output logic      out_valid,
    output log2_out_t out_data
);

    logic                     s3_valid_reg;
    logic signed [PROD_W-1:0] s3_prod_reg;
    logic signed [PROD_W-1:0] s3_prod_next;
    logic signed [31:0]       s3_log2_reg;
    logic [BAND_W-1:0]        s3_band_reg;
    logic                     s4_valid_reg;
    log2_out_t                s4_data_reg;
    log2_out_t                s4_data_next;
    logic signed [V_W-1:0]    v;

    assign s3_prod_next = PROD_W'(in_data.diff * signed'({1'b0, in_data.slope}));

    // Floor of v over 2^40 is the exponent, the low 40 bits the fraction.
    assign v = (V_W'(s3_log2_reg) <<< 16) - V_W'(s3_prod_reg);

    always_comb
    begin
        s4_data_next.band = s3_band_reg;
        s4_data_next.expo = v[V_W-1 -: E_W];
        s4_data_next.seg  = v[R_W+J_W-1 -: J_W];
        s4_data_next.rem  = v[R_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= in_valid;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_prod_reg <= s3_prod_next;
        s3_log2_reg <= in_data.log2_base;
        s3_band_reg <= in_data.band;
        s4_data_reg <= s4_data_next;
    end

    assign out_valid = s4_valid_reg;
    assign out_data  = s4_data_reg;

endmodule

### src/ead_exp2.sv
`timescale 1ns / 1ps
// 2^fraction in Q.30: segment table lookup, split interpolation multiply,
// then sum, three register stages. Depends on ead_pkg.
module ead_exp2
    import ead_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  log2_out_t in_data,
    output logic      out_valid,
    output exp2_out_t out_data
);

    logic                  s5_valid_reg;
    logic [BASE_W-1:0]     s5_base_reg;
    logic [DELTA_W-1:0]    s5_delta_reg;
    logic [R_W-1:0]        s5_rem_reg;
    logic signed [E_W-1:0] s5_expo_reg;
    logic [BAND_W-1:0]     s5_band_reg;
    logic                  s6_valid_reg;
    logic [PP_W-1:0]       s6_phi_reg;
    logic [PP_W-1:0]       s6_plo_reg;
    logic [BASE_W-1:0]     s6_base_reg;
    logic signed [E_W-1:0] s6_expo_reg;
    logic [BAND_W-1:0]     s6_band_reg;
    logic                  s7_valid_reg;
    exp2_out_t             s7_data_reg;
    exp2_out_t             s7_data_next;
    logic [PP_W-1:0]       phi_next;
    logic [PP_W-1:0]       plo_next;
    logic [SUM_W-1:0]      interp_sum;

    assign phi_next = PP_W'(s5_delta_reg * s5_rem_reg[R_W-1:R_HALF]);
    assign plo_next = PP_W'(s5_delta_reg * s5_rem_reg[R_HALF-1:0]);

    assign interp_sum = (SUM_W'(s6_phi_reg) << R_HALF) + SUM_W'(s6_plo_reg);

    always_comb
    begin
        s7_data_next.band     = s6_band_reg;
        s7_data_next.expo     = s6_expo_reg;
        s7_data_next.mant_q30 = s6_base_reg + BASE_W'(interp_sum[SUM_W-1:R_W]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
        end
        else
        begin
            s5_valid_reg <= in_valid;
            s6_valid_reg <= s5_valid_reg;
            s7_valid_reg <= s6_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s5_base_reg  <= POW_BASE[in_data.seg];
        s5_delta_reg <= POW_DELTA[in_data.seg];
        s5_rem_reg   <= in_data.rem;
        s5_expo_reg  <= in_data.expo;
        s5_band_reg  <= in_data.band;
        s6_phi_reg   <= phi_next;
        s6_plo_reg   <= plo_next;
        s6_base_reg  <= s5_base_reg;
        s6_expo_reg  <= s5_expo_reg;
        s6_band_reg  <= s5_band_reg;
        s7_data_reg  <= s7_data_next;
    end

    assign out_valid = s7_valid_reg;
    assign out_data  = s7_data_reg;

endmodule

### src/exponential_atmosphere_density.sv
`timescale 1ns / 1ps
// Top level of the exponential atmosphere density pipeline: band, log2 and
// exp2 stages plus mantissa rounding and exponent saturation at the output.
// Depends on ead_pkg, ead_band, ead_log2, ead_exp2.
//
//   channel   handshake        payload
//   -------   --------------   --------------------------------------------
//   input     start / busy     altitude_m
//   result    done (strobe)    density_mantissa, density_exponent, band_index
//
// Eight register stages: a result strobes done once its item has passed through all of them.
// One item is taken every cycle; busy stays low, since nothing downstream
// can hold the pipeline. Reset clears the valid bits only, so the pipeline
// comes out of reset empty.
module exponential_atmosphere_density
    import ead_pkg::*;
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic signed [ALT_W-1:0]         altitude_m,
    output logic                            done,
    output logic [MANTISSA_BITS-1:0]        density_mantissa,
    output logic signed [EXP_W-1:0]         density_exponent,
    output logic [BAND_W-1:0]               band_index
);

    logic                     accept;
    logic                     band_valid;
    band_out_t                band_data;
    logic                     log2_valid;
    log2_out_t                log2_data;
    logic                     exp2_valid;
    exp2_out_t                exp2_data;
    logic                     done_reg;
    logic [MANTISSA_BITS-1:0] mant_reg;
    logic [MANTISSA_BITS-1:0] mant_next;
    logic signed [EXP_W-1:0]  expo_reg;
    logic signed [EXP_W-1:0]  expo_next;
    logic [BAND_W-1:0]        band_reg;
    logic [30:0]              rounded;
    logic [MANTISSA_BITS:0]   mant_wide;
    logic signed [E_W:0]      expo_adj;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    ead_band u_band (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .altitude  (altitude_m),
        .out_valid (band_valid),
        .out_data  (band_data)
    );

    ead_log2 u_log2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (band_valid),
        .in_data   (band_data),
        .out_valid (log2_valid),
        .out_data  (log2_data)
    );

    ead_exp2 u_exp2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (log2_valid),
        .in_data   (log2_data),
        .out_valid (exp2_valid),
        .out_data  (exp2_data)
    );

    // Round the Q.30 fraction half up; a carry out bumps the exponent.
    assign rounded   = {1'b0, exp2_data.mant_q30[29:0]} + 31'(ROUND_HALF);
    assign mant_wide = (MANTISSA_BITS + 1)'(rounded >> MANT_SHIFT);

    always_comb
    begin
        mant_next = mant_wide[MANTISSA_BITS-1:0];
        expo_adj  = (E_W + 1)'(exp2_data.expo);
        if (mant_wide[MANTISSA_BITS])
        begin
            mant_next = '0;
            expo_adj  = expo_adj + (E_W + 1)'(1);
        end
        expo_next = EXP_W'(expo_adj);
        if (expo_adj > (E_W + 1)'(127))
        begin
            expo_next = EXP_W'(127);
            mant_next = '1;
        end
        else if (expo_adj < -(E_W + 1)'(128))
        begin
            expo_next = -EXP_W'(128);
            mant_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= exp2_valid;
    end

    always_ff @(posedge clk)
    begin
        mant_reg <= mant_next;
        expo_reg <= expo_next;
        band_reg <= exp2_data.band;
    end

    assign done             = done_reg;
    assign density_mantissa = mant_reg;
    assign density_exponent = expo_reg;
    assign band_index       = band_reg;

endmodule

### src/ead_checker.sv
`timescale 1ns / 1ps
// Port-level checks on the exponential atmosphere density pipeline:
// fixed latency in both directions and band selection. Depends on ead_pkg.
module ead_checker
    import ead_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     start,
    input logic                     busy,
    input logic signed [ALT_W-1:0]  altitude_m,
    input logic                     done,
    input logic [BAND_W-1:0]        band_index
);

    a_item_returns: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted item produced no result");

    a_no_stray_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without a matching item");

    a_band_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (band_index < BAND_W'(BAND_LIMIT)))
        else $error("band index out of range");

    a_low_band: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ($past(altitude_m, LATENCY) < ALT_W'(BAND_BASE_M[1])))
            |-> (band_index == '0))
        else $error("low altitude not in the first band");

endmodule

bind exponential_atmosphere_density ead_checker u_ead_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .altitude_m (altitude_m),
    .done       (done),
    .band_index (band_index)
);

### sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for exponential_atmosphere_density: directed table, carry probes,
// then random altitude bursts, each result checked against a given value or an independent
// fixed-point density model. Depends on ead_pkg and the exponential_atmosphere_density RTL.
module testbench;

    localparam int ALT_W      = ead_pkg::ALT_W;
    localparam int MANT_W     = ead_pkg::MANTISSA_BITS;
    localparam int EXPO_W     = ead_pkg::EXP_W;
    localparam int BANDS_W    = ead_pkg::BAND_W;
    localparam int FRAC_SHIFT = 30 - MANT_W;
    localparam int NBANDS     = 23;
    localparam int RANDOM_ITEMS = 400;
    localparam int STALL_LIMIT  = 2000;
    localparam int ALT_MAX      = 4194303;
    localparam int ALT_MIN      = -4194304;

    localparam longint unsigned LOG2E_SCALED = 64'd1586259972792;
    localparam longint unsigned UNITY_Q30    = 64'd1073741824;

    localparam int BAND_FLOOR [NBANDS] = '{
        0, 25000, 30000, 40000, 50000, 60000, 70000, 80000, 90000, 100000,
        150000, 200000, 250000, 300000, 350000, 400000, 450000, 500000,
        600000, 700000, 800000, 900000, 1000000
    };
    localparam int unsigned SCALE_HEIGHT [NBANDS] = '{
        7249, 6349, 6682, 7554, 8382, 7714, 6549, 5799, 5382, 5877,
        22523, 37105, 45546, 53628, 53298, 58515, 60828, 63822,
        71835, 88667, 124640, 181050, 268000
    };
    localparam int FLOOR_LOG2_Q24 [NBANDS] = '{
        4912063, -78529988, -97590553, -133813710, -165856351, -194732105,
        -226107608, -263064222, -304803966, -349776787, -483984465,
        -532501002, -565117471, -591688700, -614255463, -636962050,
        -657644290, -677539944, -715465013, -749159684, -776457690,
        -795877214, -809246508
    };
    localparam longint unsigned ROOT2_STEP [6] = '{
        64'd1518500250, 64'd1276901417, 64'd1170923762,
        64'd1121280436, 64'd1097253708, 64'd1085434106
    };

    typedef struct packed {
        logic [MANT_W-1:0]        mantissa;
        logic signed [EXPO_W-1:0] exponent;
        logic [BANDS_W-1:0]       band;
    } density_t;

    typedef struct packed {
        logic signed [ALT_W-1:0] altitude;
        bit                      known;
        density_t                want;
    } altitude_row_t;

    localparam density_t DENSE_SAT = '{mantissa: '1, exponent: 8'sd127, band: 5'd0};
    localparam density_t NO_VALUE  = '0;

    localparam int DIRECTED_ROWS = 22;
    localparam altitude_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{altitude: ALT_MIN,  known: 1'b1, want: DENSE_SAT},
        '{altitude: -1000000, known: 1'b1, want: DENSE_SAT},
        '{altitude: -700000,  known: 1'b1, want: DENSE_SAT},
        '{altitude: -641000,  known: 1'b0, want: NO_VALUE},
        '{altitude: -50000,   known: 1'b0, want: NO_VALUE},
        '{altitude: -1,       known: 1'b0, want: NO_VALUE},
        '{altitude: 0,        known: 1'b0, want: NO_VALUE},
        '{altitude: 1,        known: 1'b0, want: NO_VALUE},
        '{altitude: 24999,    known: 1'b0, want: NO_VALUE},
        '{altitude: 25000,    known: 1'b0, want: NO_VALUE},
        '{altitude: 99999,    known: 1'b0, want: NO_VALUE},
        '{altitude: 100000,   known: 1'b0, want: NO_VALUE},
        '{altitude: 149999,   known: 1'b0, want: NO_VALUE},
        '{altitude: 150000,   known: 1'b0, want: NO_VALUE},
        '{altitude: 500000,   known: 1'b0, want: NO_VALUE},
        '{altitude: 999999,   known: 1'b0, want: NO_VALUE},
        '{altitude: 1000000,  known: 1'b0, want: NO_VALUE},
        '{altitude: 1000001,  known: 1'b0, want: NO_VALUE},
        '{altitude: 4000000,  known: 1'b0, want: NO_VALUE},
        '{altitude: ALT_MAX,  known: 1'b0, want: NO_VALUE},
        '{altitude: 2796202,  known: 1'b0, want: NO_VALUE},
        '{altitude: -2796203, known: 1'b0, want: NO_VALUE}
    };

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic signed [ALT_W-1:0]   altitude_m;
    logic                      done;
    logic [MANT_W-1:0]         density_mantissa;
    logic signed [EXPO_W-1:0]  density_exponent;
    logic [BANDS_W-1:0]        band_index;

    bit                        row_known;
    density_t                  row_want;
    density_t                  pending_density [$];
    int                        error_count;
    int                        stall_cycles;

    exponential_atmosphere_density DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .altitude_m       (altitude_m),
        .done             (done),
        .density_mantissa (density_mantissa),
        .density_exponent (density_exponent),
        .band_index       (band_index)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic longint unsigned q30_product(longint unsigned a, longint unsigned b);
        return (a * b + 64'd536870912) >> 30;
    endfunction

    function automatic density_t predict_density(input logic signed [ALT_W-1:0] alt,
                                                 output bit carried);
        int              band;
        int              e;
        longint          d;
        longint          slope;
        longint          v;
        logic [39:0]     f;
        logic [5:0]      seg;
        longint unsigned rem;
        longint unsigned seg_lo;
        longint unsigned seg_hi;
        longint unsigned m;
        longint unsigned mant;
        density_t        r;
        band = 0;
        for (int i = 1; i < NBANDS; i++)
        begin
            if (int'(alt) >= BAND_FLOOR[i])
                band = i;
        end
        d     = longint'(alt) - longint'(BAND_FLOOR[band]);
        slope = longint'(LOG2E_SCALED / longint'(SCALE_HEIGHT[band]));
        v     = longint'(FLOOR_LOG2_Q24[band]) * 65536 - d * slope;
        e     = int'(v >>> 40);
        f     = v[39:0];
        seg   = f[39:34];
        rem   = longint'(f[33:0]);
        seg_lo = UNITY_Q30;
        for (int k = 0; k < 6; k++)
        begin
            if (seg[5-k])
                seg_lo = q30_product(seg_lo, ROOT2_STEP[k]);
        end
        seg_hi = q30_product(seg_lo, ROOT2_STEP[5]);
        if (seg_hi < seg_lo)
            seg_hi = seg_lo;
        m    = seg_lo + (((seg_hi - seg_lo) * rem) >> 34);
        mant = (m - UNITY_Q30 + (64'd1 << (FRAC_SHIFT - 1))) >> FRAC_SHIFT;
        carried = (mant >> MANT_W) != 0;
        if (carried)
        begin
            mant = 0;
            e    = e + 1;
        end
        if (e > 127)
        begin
            e    = 127;
            mant = (64'd1 << MANT_W) - 1;
        end
        else if (e < -128)
        begin
            e    = -128;
            mant = 0;
        end
        r.mantissa = mant[MANT_W-1:0];
        r.exponent = e[EXPO_W-1:0];
        r.band     = band[BANDS_W-1:0];
        return r;
    endfunction

    function automatic logic signed [ALT_W-1:0] random_altitude();
        int b;
        int span;
        int pick;
        pick = $urandom_range(9, 0);
        b    = $urandom_range(NBANDS - 1, 0);
        span = (b < NBANDS - 1) ? BAND_FLOOR[b+1] - BAND_FLOOR[b] : ALT_MAX - BAND_FLOOR[b];
        if (pick <= 3)
            return ALT_W'(BAND_FLOOR[b] + int'($urandom_range(span - 1, 0)));
        else if (pick == 4)
            return ALT_W'(BAND_FLOOR[b] + int'($urandom_range(6, 0)) - 3);
        else if (pick <= 7)
            return ALT_W'(int'($urandom_range(4050000, 0)) - 50000);
        else
            return ALT_W'($urandom_range(32'h7FFFFF, 0));
    endfunction

    task automatic check_density(input density_t got, input density_t want);
        if (got.mantissa !== want.mantissa)
        begin
            $error("density_mantissa: expected %0d, got %0d", want.mantissa, got.mantissa);
            error_count++;
        end
        if (got.exponent !== want.exponent)
        begin
            $error("density_exponent: expected %0d, got %0d", want.exponent, got.exponent);
            error_count++;
        end
        if (got.band !== want.band)
        begin
            $error("band_index: expected %0d, got %0d", want.band, got.band);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_monitor
        density_t got;
        bit       carried;
        if (rst_n)
        begin
            if (done)
            begin
                got = '{mantissa: density_mantissa, exponent: density_exponent,
                        band: band_index};
                if (pending_density.size() == 0)
                begin
                    $error("unexpected result: mantissa %0d exponent %0d band %0d",
                           got.mantissa, got.exponent, got.band);
                    error_count++;
                end
                else
                    check_density(got, pending_density.pop_front());
            end
            if (start && !busy)
            begin
                if (row_known)
                    pending_density.push_back(row_want);
                else
                    pending_density.push_back(predict_density(altitude_m, carried));
            end
            if ((start && !busy) || done)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic send_altitude(input logic signed [ALT_W-1:0] alt, input bit known,
                                 input density_t want);
        @(negedge clk);
        start      <= 1'b1;
        altitude_m <= alt;
        row_known  <= known;
        row_want   <= want;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic idle_cycles(input int n);
        repeat (n)
        begin
            @(negedge clk);
            start      <= 1'b0;
            altitude_m <= ALT_W'($urandom);
            row_known  <= 1'b0;
        end
    endtask

    task automatic drain_results();
        @(negedge clk);
        start     <= 1'b0;
        row_known <= 1'b0;
        while (pending_density.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        logic signed [ALT_W-1:0] carry_alt [$];
        longint                  num;
        longint                  slope;
        longint                  h;
        bit                      carried;
        bit                      drained_once;
        density_t                probe;
        int                      sent;
        int                      burst;

        rst_n        = 1'b0;
        start        = 1'b0;
        altitude_m   = '0;
        row_known    = 1'b0;
        row_want     = '0;
        error_count  = 0;
        stall_cycles = 0;
        drained_once = 1'b0;

        // find altitudes just past an exponent step, where rounding carries into the exponent
        for (int b = 0; b < NBANDS; b++)
        begin
            slope = longint'(LOG2E_SCALED / longint'(SCALE_HEIGHT[b]));
            for (int n = -70; n <= 12; n++)
            begin
                num = longint'(FLOOR_LOG2_Q24[b]) * 65536 - longint'(n) * (64'sd1 <<< 40);
                for (int off = 0; off < 3; off++)
                begin
                    h = longint'(BAND_FLOOR[b]) + num / slope + off;
                    if (h >= ALT_MIN && h <= ALT_MAX && carry_alt.size() < 4)
                    begin
                        probe = predict_density(ALT_W'(h), carried);
                        if (carried && probe.band == b)
                            carry_alt.push_back(ALT_W'(h));
                    end
                end
            end
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_altitude(DIRECTED[i].altitude, DIRECTED[i].known, DIRECTED[i].want);
        foreach (carry_alt[i])
            send_altitude(carry_alt[i], 1'b0, NO_VALUE);
        drain_results();

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            burst = $urandom_range(30, 1);
            for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++)
            begin
                send_altitude(random_altitude(), 1'b0, NO_VALUE);
                sent++;
            end
            if (!drained_once && sent >= RANDOM_ITEMS / 2)
            begin
                drain_results();
                drained_once = 1'b1;
            end
            else if ($urandom_range(3, 0) != 0)
                idle_cycles($urandom_range(12, 1));
        end

        drain_results();
        repeat (ead_pkg::LATENCY + 4) @(posedge clk);
        if (pending_density.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_density.size());
            error_count++;
        end
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
